// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Storage defaults
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;

  // Byte-padded stream widths
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_HEAD = 2'd0,
    CMD_PUSH_TAIL = 2'd1,
    CMD_POP_HEAD  = 2'd2,
    CMD_POP_TAIL  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic exec;   // transfer accepted, run the command
    logic load;   // move the result into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_busy;  // output register holds a result not taken this cycle
  } dp_stat_t;

endpackage

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer: accepts one command, then waits for the output slot.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbd_pkg::dp_stat_t  stat,
  output rbd_pkg::ctrl_cmd_t cmd
);

  rbd_pkg::state_t state;
  rbd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rbd_pkg::ST_IDLE: begin
        if (in_valid) state_next = rbd_pkg::ST_RESULT;
      end
      rbd_pkg::ST_RESULT: begin
        if (!stat.out_busy) state_next = rbd_pkg::ST_IDLE;
      end
      default: begin
        state_next = rbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      rbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      rbd_pkg::ST_RESULT: begin
        cmd.load = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/rbd_datapath.sv =====
// ----------------------------------------------------------------------------
// rbd_datapath
// Store, head/tail pointers, fill count, capacity register, result register.
// ----------------------------------------------------------------------------
module rbd_datapath #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rbd_pkg::ctrl_cmd_t        cmd,
  output rbd_pkg::dp_stat_t         stat,
  input  logic                      cfg_wr_en,
  input  logic [rbd_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic [rbd_pkg::CMD_W-1:0] in_cmd,
  input  logic [rbd_pkg::WORD_W-1:0] in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rbd_pkg::STAT_W-1:0] out_status,
  output logic [rbd_pkg::WORD_W-1:0] out_pop_data,
  output logic [rbd_pkg::CAP_W-1:0] out_count
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = ($clog2(DEPTH + 1) > rbd_pkg::CAP_W) ?
                          $clog2(DEPTH + 1) : rbd_pkg::CAP_W;
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);

  logic [DATA_WIDTH-1:0]     mem [DEPTH];
  logic [rbd_pkg::CAP_W-1:0] capacity;
  logic [PTR_W-1:0]          head, head_next;
  logic [PTR_W-1:0]          tail, tail_next;
  logic [FILL_W-1:0]         fill, fill_next;

  logic [FILL_W-1:0]         cap_raw, cap_eff;
  logic [FILL_W-1:0]         head_p1, tail_p1;
  logic [PTR_W-1:0]          head_inc, head_dec, tail_inc, tail_dec, cap_last;
  logic                      full, empty;

  logic [PTR_W-1:0]          addr;
  logic                      wr_en, rd_en, is_push;
  logic [rbd_pkg::STAT_W-1:0] status_c;

  // per-item result, held until the output slot frees up
  logic [DATA_WIDTH-1:0]      rd_data;
  logic                       res_pop;
  logic [rbd_pkg::STAT_W-1:0] res_status;
  logic [rbd_pkg::CAP_W-1:0]  res_count;

  // clamp capacity to 1..DEPTH
  always_comb begin
    cap_raw = FILL_W'(capacity);
    if (cap_raw == '0)         cap_eff = FILL_W'(1);
    else if (cap_raw > DEPTH_F) cap_eff = DEPTH_F;
    else                        cap_eff = cap_raw;
  end

  // wrap by compare, never divide
  assign cap_last = PTR_W'(cap_eff - FILL_W'(1));
  assign head_p1  = FILL_W'(head) + FILL_W'(1);
  assign tail_p1  = FILL_W'(tail) + FILL_W'(1);
  assign head_inc = (head_p1 >= cap_eff) ? '0 : PTR_W'(head_p1);
  assign tail_inc = (tail_p1 >= cap_eff) ? '0 : PTR_W'(tail_p1);
  assign head_dec = (head == '0) ? cap_last : head - PTR_W'(1);
  assign tail_dec = (tail == '0) ? cap_last : tail - PTR_W'(1);

  assign full    = (fill >= cap_eff);
  assign empty   = (fill == '0);
  assign is_push = (in_cmd == rbd_pkg::CMD_PUSH_HEAD) || (in_cmd == rbd_pkg::CMD_PUSH_TAIL);

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    addr      = head;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    status_c  = rbd_pkg::STAT_OK;
    case (in_cmd)
      rbd_pkg::CMD_PUSH_HEAD: begin
        addr = head_dec;
        if (full) begin
          status_c = rbd_pkg::STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          head_next = head_dec;
          fill_next = fill + FILL_W'(1);
        end
      end
      rbd_pkg::CMD_PUSH_TAIL: begin
        addr = tail;
        if (full) begin
          status_c = rbd_pkg::STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_next = tail_inc;
          fill_next = fill + FILL_W'(1);
        end
      end
      rbd_pkg::CMD_POP_HEAD: begin
        addr = head;
        if (empty) begin
          status_c = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en     = 1'b1;
          head_next = head_inc;
          fill_next = fill - FILL_W'(1);
        end
      end
      rbd_pkg::CMD_POP_TAIL: begin
        addr = tail_dec;
        if (empty) begin
          status_c = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en     = 1'b1;
          tail_next = tail_dec;
          fill_next = fill - FILL_W'(1);
        end
      end
      default: begin
        status_c = rbd_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rbd_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // store: one write or one registered read per item
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[addr] <= DATA_WIDTH'(in_data);
    end
    if (cmd.exec && rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_pop    <= rd_en;
      res_status <= status_c;
      res_count  <= rbd_pkg::CAP_W'(fill_next);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status   <= res_status;
      out_count    <= res_count;
      out_pop_data <= res_pop ? rbd_pkg::WORD_W'(rd_data) : '0;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  // a refused push leaves the deque untouched
  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && full) |=>
      ($stable(head) && $stable(tail) && $stable(fill)))
    else $error("refused push changed deque state");

  // an accepted push grows the fill by one
  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && !full) |=> (fill == $past(fill) + FILL_W'(1)))
    else $error("push did not increment fill");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  // fill stays within the store
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (fill <= DEPTH_F))
    else $error("fill exceeded depth");

endmodule

// ===== rtl/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of data words in a circular store.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one command per transfer. tuser carries the command
// (push head, push tail, pop head, pop tail), tdata the word to push.
// Output stream (m_axis): exactly one result per command. tuser carries the
// status (ok, full, empty), tdata the popped word (zero unless a pop
// succeeded) and the number of stored words after the command.
// Config: cfg_wr_en/cfg_wr_data set the capacity (wrap point of both
// pointers, clamped to 1..DEPTH). Write it only while the deque is empty
// and idle.
// Timing: a command is taken on its input transfer (pointers, count and store
// updated, store read registered into the result stage), and its result is
// loaded into the output register once that register is free, which raises
// m_axis_tvalid. A new command is not accepted until the previous result has
// been loaded, because of the registered store read and the two-state
// sequencer.
// Stall: a result waiting on m_axis_tready lets one more command execute; it
// parks in the result stage and s_axis_tready stays low until the output
// register frees up.
// Reset: pointers and count clear, capacity returns to 16; store contents
// are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rbd_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [31:0] push_data
  input  logic [rbd_pkg::CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rbd_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [31:0] pop_data, [36:32] count
  output logic [rbd_pkg::STAT_W-1:0]    m_axis_tuser,   // [1:0] status
  // capacity register
  input  logic                          cfg_wr_en,
  input  logic [rbd_pkg::CAP_W-1:0]     cfg_wr_data
);

  rbd_pkg::ctrl_cmd_t ctrl_cmd;
  rbd_pkg::dp_stat_t  dp_stat;

  logic [rbd_pkg::WORD_W-1:0] pop_data;
  logic [rbd_pkg::CAP_W-1:0]  count;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  rbd_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctrl_cmd),
    .stat         (dp_stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_cmd       (s_axis_tuser),
    .in_data      (s_axis_tdata[rbd_pkg::WORD_W-1:0]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_status   (m_axis_tuser),
    .out_pop_data (pop_data),
    .out_count    (count)
  );

  // pack result: pop_data low, count above, zero pad to 40 bits
  assign m_axis_tdata = {
    {(rbd_pkg::M_TDATA_W - rbd_pkg::WORD_W - rbd_pkg::CAP_W){1'b0}},
    count,
    pop_data
  };

endmodule

// ===== tb/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker
// Watches both streams and the capacity port of ring_buffer_deque, keeps its
// own copy of the deque, and matches each result transfer against the reply
// owed to the oldest command that has not yet been answered.
// ----------------------------------------------------------------------------
module deque_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [rbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [rbd_pkg::CMD_W-1:0]     s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [rbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic [rbd_pkg::STAT_W-1:0]    m_axis_tuser,
  input  logic                          cfg_wr_en,
  input  logic [rbd_pkg::CAP_W-1:0]     cfg_wr_data,
  output int                            n_errors,
  output int                            n_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = rbd_pkg::DEPTH_DEFAULT;

  typedef struct packed {
    rbd_pkg::status_t           status;
    logic [rbd_pkg::WORD_W-1:0] word;
    logic [rbd_pkg::CAP_W-1:0]  count;
  } reply_t;

  logic [rbd_pkg::WORD_W-1:0] slot_words [SLOTS];
  int                         head_slot;
  int                         tail_slot;
  int                         held;
  logic [rbd_pkg::CAP_W-1:0]  cap_setting;
  reply_t                     owed_replies [$];
  reply_t                     want;
  reply_t                     got;
  int                         mismatches = 0;

  // Register value clamped to 1..SLOTS.
  function automatic int usable_slots(logic [rbd_pkg::CAP_W-1:0] setting);
    if (setting == '0) return 1;
    if (int'(setting) > SLOTS) return SLOTS;
    return int'(setting);
  endfunction

  function automatic int advance(int slot, int span);
    return (slot + 1 >= span) ? 0 : slot + 1;
  endfunction

  function automatic int retreat(int slot, int span);
    return (slot == 0) ? span - 1 : slot - 1;
  endfunction

  // Runs one command on the local deque and returns the reply it owes.
  function automatic reply_t apply_command(rbd_pkg::cmd_t op,
                                           logic [rbd_pkg::WORD_W-1:0] word);
    reply_t r;
    int     span;
    span     = usable_slots(cap_setting);
    r.status = rbd_pkg::STAT_OK;
    r.word   = '0;
    case (op)
      rbd_pkg::CMD_PUSH_HEAD, rbd_pkg::CMD_PUSH_TAIL: begin
        if (held >= span) begin
          r.status = rbd_pkg::STAT_FULL;
        end else if (op == rbd_pkg::CMD_PUSH_HEAD) begin
          head_slot = retreat(head_slot, span);
          slot_words[head_slot] = word;
          held++;
        end else begin
          slot_words[tail_slot] = word;
          tail_slot = advance(tail_slot, span);
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = rbd_pkg::STAT_EMPTY;
        end else if (op == rbd_pkg::CMD_POP_HEAD) begin
          r.word    = slot_words[head_slot];
          head_slot = advance(head_slot, span);
          held--;
        end else begin
          tail_slot = retreat(tail_slot, span);
          r.word    = slot_words[tail_slot];
          held--;
        end
      end
    endcase
    r.count = rbd_pkg::CAP_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_words[i] = '0;
      head_slot   = 0;
      tail_slot   = 0;
      held        = 0;
      cap_setting = rbd_pkg::CAP_RESET;
      owed_replies.delete();
    end else begin
      if (cfg_wr_en) cap_setting = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        owed_replies.push_back(apply_command(rbd_pkg::cmd_t'(s_axis_tuser),
                                             s_axis_tdata[rbd_pkg::WORD_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = rbd_pkg::status_t'(m_axis_tuser);
        got.word   = m_axis_tdata[rbd_pkg::WORD_W-1:0];
        got.count  = m_axis_tdata[rbd_pkg::WORD_W +: rbd_pkg::CAP_W];
        if (owed_replies.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.word !== want.word) begin
            $error("pop_data: expected %h, got %h", want.word, got.word);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
        end
      end
    end
    n_waiting <= owed_replies.size();
    n_errors  <= mismatches;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for ring_buffer_deque: directed corner cases, then phases of
// random push/pop traffic over a spread of capacities and idle patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRESSURE_PH = 6;        // phase with a mid-run pause until all replies are back
  // Capacity per phase: reset value, both out-of-range kinds, tiny and odd sizes.
  localparam logic [rbd_pkg::CAP_W-1:0] CAP_PLAN [PHASES] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd3, 5'd8, 5'd15, 5'd4, 5'd9};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [rbd_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;    // [31:0] push_data
  logic [rbd_pkg::CMD_W-1:0]     s_axis_tuser = '0;    // [1:0] cmd
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rbd_pkg::M_TDATA_W-1:0] m_axis_tdata;  // [31:0] pop_data, [36:32] count
  logic [rbd_pkg::STAT_W-1:0]    m_axis_tuser;  // [1:0] status
  logic                          cfg_wr_en = 1'b0;
  logic [rbd_pkg::CAP_W-1:0]     cfg_wr_data = '0;

  int n_errors;
  int n_waiting;
  int cycle_count = 0;
  int tx_idle_pct = 0;   // chance per slot that the sender holds off
  int rx_stall_pct = 0;  // chance per cycle that the sink drops tready

  // Stimulus-side view of occupancy, only used to steer traffic toward
  // full and empty; correctness is judged in the checker.
  int level = 0;
  int room  = rbd_pkg::DEPTH_DEFAULT;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ring_buffer_deque DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  deque_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .n_errors      (n_errors),
    .n_waiting     (n_waiting)
  );

  // Sink side: random backpressure at the phase's stall rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly random words, with the sign and all-ones/all-zeros corners mixed in.
  function automatic logic [rbd_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // One command transfer. Called at a rising edge; returns at the edge
  // where the transfer happened, with tvalid still high.
  task automatic send_item(input rbd_pkg::cmd_t op,
                           input logic [rbd_pkg::WORD_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == rbd_pkg::CMD_PUSH_HEAD || op == rbd_pkg::CMD_PUSH_TAIL) begin
      if (level < room) level++;
    end else if (level > 0) begin
      level--;
    end
  endtask

  // Sender goes quiet until every reply has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
  endtask

  // Pop from random ends until empty.
  task automatic drain();
    while (level > 0)
      send_item($urandom_range(1) ? rbd_pkg::CMD_POP_HEAD : rbd_pkg::CMD_POP_TAIL,
                pick_word());
  endtask

  initial begin
    logic          filling;
    int            push_bias;
    rbd_pkg::cmd_t op;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity of 16. Both empty refusals first,
    // then the sign corners at both ends, then fill to full so every store
    // slot has been written before any capacity change, then both full
    // refusals.
    send_item(rbd_pkg::CMD_POP_HEAD, 32'hdead_beef);
    send_item(rbd_pkg::CMD_POP_TAIL, 32'h1234_5678);
    send_item(rbd_pkg::CMD_PUSH_TAIL, 32'h8000_0000);
    send_item(rbd_pkg::CMD_PUSH_TAIL, 32'h7fff_ffff);
    send_item(rbd_pkg::CMD_PUSH_HEAD, 32'hffff_ffff);
    send_item(rbd_pkg::CMD_PUSH_HEAD, 32'h0000_0000);
    send_item(rbd_pkg::CMD_POP_TAIL, 32'h0);
    send_item(rbd_pkg::CMD_POP_HEAD, 32'h0);
    for (int k = 0; k < 14; k++)
      send_item(k[0] ? rbd_pkg::CMD_PUSH_HEAD : rbd_pkg::CMD_PUSH_TAIL,
                k[1] ? 32'haaaa_aaaa : 32'h5555_5555);
    send_item(rbd_pkg::CMD_PUSH_HEAD, 32'h0bad_cafe);
    send_item(rbd_pkg::CMD_PUSH_TAIL, 32'hcafe_0bad);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // Capacity only moves while the deque is empty and quiet.
      settle();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= CAP_PLAN[p];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      room = (CAP_PLAN[p] == 0) ? 1 :
             (int'(CAP_PLAN[p]) > rbd_pkg::DEPTH_DEFAULT) ? rbd_pkg::DEPTH_DEFAULT :
             int'(CAP_PLAN[p]);

      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase

      // Swing between filling and draining so both refusals keep showing up;
      // the swing turns only after a few knocks on the full or empty wall.
      filling = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PRESSURE_PH && k == PHASE_ITEMS / 2) settle();
        push_bias = filling ? 75 : 25;
        if ($urandom_range(99) < push_bias)
          op = $urandom_range(1) ? rbd_pkg::CMD_PUSH_HEAD : rbd_pkg::CMD_PUSH_TAIL;
        else
          op = $urandom_range(1) ? rbd_pkg::CMD_POP_HEAD : rbd_pkg::CMD_POP_TAIL;
        send_item(op, pick_word());
        if (filling && level >= room && $urandom_range(3) == 0) filling = 1'b0;
        else if (!filling && level == 0 && $urandom_range(3) == 0) filling = 1'b1;
      end
      drain();
    end

    settle();
    rx_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
